>>> sv/grqt_pkg.sv
// ----------------------------------------------------------------------------
// grqt_pkg
// Types and constants shared by the quarter-turn glyph rasteriser modules.
// ----------------------------------------------------------------------------
package grqt_pkg;

    // Item kinds as carried on the slave-side tuser.
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_BYTE  = 1'b1
    } t_kind;

    // Rotation codes, in quarter turns.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Index of the last bit of a bitmap byte.
    localparam logic [2:0] BIT_LAST = 3'd7;

    // Packed widths of the stream payloads.
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 56;

    // One queued item, start metrics and bitmap byte side by side.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] anchor_x;
        logic signed [15:0] anchor_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  offset_x;
        logic signed [7:0]  offset_y;
        logic [1:0]         rotation;
        logic [15:0]        ink_color;
        logic [7:0]         bitmap_byte;
    } t_item;

    // One pixel write.
    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [15:0]        color;
    } t_pixel;

    // Handshake between the queue and the back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

>>> sv/grqt_front.sv
// ----------------------------------------------------------------------------
// grqt_front
// Accepts input transfers, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module grqt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [grqt_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    output grqt_pkg::t_queue_out          o_q,
    input  logic                          i_q_pop
);

    grqt_pkg::t_item                  r_mem [grqt_pkg::QUEUE_DEPTH];
    logic [grqt_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [grqt_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [grqt_pkg::QUEUE_AW:0]      r_count;
    logic [grqt_pkg::QUEUE_AW:0]      n_count;
    grqt_pkg::t_item                  w_item;
    logic                             w_push;
    logic                             w_pop;

    // Unpack the transfer; a start carries metrics, a byte item only its bits.
    always_comb begin
        w_item              = '0;
        w_item.kind         = grqt_pkg::t_kind'(i_s_tuser);
        if (w_item.kind == grqt_pkg::KIND_START) begin
            w_item.anchor_x     = i_s_tdata[15:0];
            w_item.anchor_y     = i_s_tdata[31:16];
            w_item.glyph_width  = i_s_tdata[39:32];
            w_item.glyph_height = i_s_tdata[47:40];
            w_item.offset_x     = i_s_tdata[55:48];
            w_item.offset_y     = i_s_tdata[63:56];
            w_item.rotation     = i_s_tdata[65:64];
            w_item.ink_color    = i_s_tdata[81:66];
        end else begin
            w_item.bitmap_byte  = i_s_tdata[89:82];
        end
    end

    assign o_s_tready = (r_count != (grqt_pkg::QUEUE_AW+1)'(grqt_pkg::QUEUE_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_q_pop && (r_count != '0);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Occupancy.
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd_ptr];

endmodule

>>> sv/grqt_back.sv
// ----------------------------------------------------------------------------
// grqt_back
// Applies glyph metrics; bitmap bits become pixels one a cycle unless stalled.
// ----------------------------------------------------------------------------
module grqt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grqt_pkg::t_queue_out i_q,
    output logic                 o_q_pop,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output grqt_pkg::t_pixel     o_m_pixel,
    output logic                 o_m_last
);

    // Glyph state.
    logic signed [15:0] r_origin_x;
    logic signed [15:0] r_origin_y;
    logic [7:0]         r_width;
    logic [7:0]         r_height;
    logic signed [7:0]  r_xoff;
    logic signed [7:0]  r_yoff;
    logic [1:0]         r_rot;
    logic [15:0]        r_color;
    logic [7:0]         r_col;
    logic [7:0]         r_row;

    // Bit walker.
    logic               r_busy;
    logic [2:0]         r_bit;
    logic [7:0]         r_byte;

    // Pending pixel, held until it is known whether it ends its byte.
    logic               r_p_valid;
    logic               r_p_done;
    grqt_pkg::t_pixel   r_p_pix;

    // Output register.
    logic               r_o_valid;
    logic               r_o_last;
    grqt_pkg::t_pixel   r_o_pix;

    logic               w_in_glyph;
    logic               w_emit;
    logic               w_end;
    logic               w_o_free;
    logic               w_adv;
    logic               w_p_move;
    logic               w_start;
    logic signed [9:0]  w_ic;
    logic signed [9:0]  w_jc;
    logic signed [9:0]  w_px;
    logic signed [9:0]  w_py;
    grqt_pkg::t_pixel   w_pix;
    logic [8:0]         w_col_next;

    // Walker control and stall.
    assign w_in_glyph = (r_width != 8'd0) && (r_row < r_height);
    assign w_emit     = r_busy && w_in_glyph && r_byte[7];
    assign w_end      = r_busy && (!w_in_glyph || (r_bit == grqt_pkg::BIT_LAST));
    assign w_o_free   = !r_o_valid || i_m_ready;
    assign w_adv      = r_busy && !(w_emit && r_p_valid && !w_o_free);
    assign w_p_move   = r_p_valid && w_o_free && (r_p_done || (w_adv && w_emit));
    assign o_q_pop    = i_q.valid && (!r_busy || (w_adv && w_end));
    assign w_start    = o_q_pop && (i_q.item.kind == grqt_pkg::KIND_START);
    assign w_col_next = {1'b0, r_col} + 9'd1;

    // Pixel position: offset point, quarter-turn rotation, then the anchor.
    always_comb begin
        w_ic = 10'(r_xoff) + $signed({2'b00, r_col});
        w_jc = 10'(r_yoff) + $signed({2'b00, r_row});
        case (r_rot)
            grqt_pkg::ROT_90: begin
                w_px = -w_jc;
                w_py = w_ic;
            end
            grqt_pkg::ROT_180: begin
                w_px = -w_ic;
                w_py = -w_jc;
            end
            grqt_pkg::ROT_270: begin
                w_px = w_jc;
                w_py = -w_ic;
            end
            default: begin
                w_px = w_ic;
                w_py = w_jc;
            end
        endcase
        w_pix.x     = 17'(r_origin_x) + 17'(w_px);
        w_pix.y     = 17'(r_origin_y) + 17'(w_py);
        w_pix.color = r_color;
    end

    // Glyph metrics and bit counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_xoff     <= '0;
            r_yoff     <= '0;
            r_rot      <= '0;
            r_color    <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (w_start) begin
            r_origin_x <= i_q.item.anchor_x;
            r_origin_y <= i_q.item.anchor_y;
            r_width    <= i_q.item.glyph_width;
            r_height   <= i_q.item.glyph_height;
            r_xoff     <= i_q.item.offset_x;
            r_yoff     <= i_q.item.offset_y;
            r_rot      <= i_q.item.rotation;
            r_color    <= i_q.item.ink_color;
            r_col      <= '0;
            r_row      <= '0;
        end else if (w_adv && w_in_glyph) begin
            if (w_col_next >= {1'b0, r_width}) begin
                r_col <= '0;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= w_col_next[7:0];
            end
        end
    end

    // Bit walker over the current byte, most significant bit first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
            r_byte <= '0;
        end else if (o_q_pop && (i_q.item.kind == grqt_pkg::KIND_BYTE)) begin
            r_busy <= 1'b1;
            r_bit  <= '0;
            r_byte <= i_q.item.bitmap_byte;
        end else if (w_adv && w_end) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_bit  <= r_bit + 3'd1;
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

    // Pending pixel; it is the last of its byte once the byte has ended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_done  <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_p_valid <= 1'b1;
            r_p_done  <= w_end;
        end else if (w_p_move) begin
            r_p_valid <= 1'b0;
            r_p_done  <= 1'b0;
        end else if (w_adv && w_end && r_p_valid) begin
            r_p_done  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_p_pix <= w_pix;
        end
    end

    // Output register, refilled while its content is being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_move) begin
            r_o_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_move) begin
            r_o_pix  <= r_p_pix;
            r_o_last <= r_p_done;
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_m_pixel = r_o_pix;
    assign o_m_last  = r_o_last;

endmodule

>>> sv/glyph_rasterizer_quarter_turn.sv
// ----------------------------------------------------------------------------
// glyph_rasterizer_quarter_turn
// Expands packed one-bit glyph bitmaps into rotated pixel writes.
// ----------------------------------------------------------------------------
// A start transfer (tuser low) loads the anchor, size, offsets, rotation and
// colour of a glyph into the back end. Each bitmap byte transfer (tuser high)
// is walked while the glyph is being filled: the back end walks its bits one
// a cycle unless stalled, most significant first, and gives one pixel per set
// bit inside the glyph, so a byte yields at most eight pixels at one per cycle
// while the pixel path has room. A byte that arrives once the glyph is empty or
// complete ends at its first bit with no pixel, and a byte that completes the
// glyph part-way ends in the cycle after its last bit inside the glyph. The
// bit walker takes the next item from the queue in the cycle its byte ends, and
// it holds only when a set bit finds the pixel path full. A four-entry queue
// decouples the input from the walker, and tlast marks the final pixel of each
// byte. A pixel is held until the next set bit of its byte is walked or the
// byte ends; a byte passes through the queue storage and the bit walker, and
// its pixels through the pending pixel register and the output register.
module glyph_rasterizer_quarter_turn (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // anchor_x, anchor_y, glyph_width, glyph_height, offset_x, offset_y,
    // rotation, ink_color, bitmap_byte, zero fill
    input  logic [grqt_pkg::S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [grqt_pkg::M_DATA_W-1:0] m_tdata,
    // last_of_byte
    output logic                          m_tlast
);

    grqt_pkg::t_queue_out w_q;
    logic                 w_q_pop;
    grqt_pkg::t_pixel     w_pix;

    // Front end with input queue.
    grqt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_q        (w_q),
        .i_q_pop    (w_q_pop)
    );

    // Back end: metrics, bit walker and pixel output.
    grqt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (w_q),
        .o_q_pop   (w_q_pop),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_m_pixel (w_pix),
        .o_m_last  (m_tlast)
    );

    // Pack the pixel, first field in the lowest bits.
    assign m_tdata = {6'd0, w_pix.color, w_pix.y, w_pix.x};

endmodule
